// ===== hdl/aos_pkg.sv =====
// Shared constants, types and codes for the overlap scan block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package aos_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int LIST_DEPTH  = 16;
    localparam int COORD_BITS  = 16;

    localparam int SLOT_BITS  = 6;
    localparam int SIZE_BITS  = 10;
    localparam int CAP_BITS   = 5;
    localparam int TOTAL_BITS = 5;

    localparam int IDX_BITS = $clog2(TABLE_DEPTH);
    localparam int SEL_BITS = ((IDX_BITS > SLOT_BITS) ? IDX_BITS : SLOT_BITS) + 1;
    localparam int CNT_BITS = $clog2(LIST_DEPTH + 1);
    localparam int LVL_BITS = ((CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS) + 1;
    localparam int EXT_BITS = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;

    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam int REG_BITS   = PADDR_BITS - 2;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);
    localparam logic [REG_BITS-1:0] REG_LIST_CAPACITY = REG_BITS'(0);

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [SIZE_BITS-1:0]  w;
        logic [SIZE_BITS-1:0]  h;
    } box_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SUMMARY
    } state_t;

    typedef struct packed {
        logic write_slot;
        logic load_query;
        logic advance;
        logic emit_hit;
        logic emit_summary;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic hit;
        logic last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/aos_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on aos_pkg for field widths.
`timescale 1ns / 1ps

interface aos_item_if import aos_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [SLOT_BITS-1:0]         slot_index;
    logic                         slot_occupied;
    logic                         is_explosion;
    logic signed [COORD_BITS-1:0] anchor_x;
    logic signed [COORD_BITS-1:0] anchor_y;
    logic [SIZE_BITS-1:0]         box_width;
    logic [SIZE_BITS-1:0]         box_height;
    logic                         keep_found;

    modport source (
        output valid, kind, slot_index, slot_occupied, is_explosion,
               anchor_x, anchor_y, box_width, box_height, keep_found,
        input  ready
    );

    modport sink (
        input  valid, kind, slot_index, slot_occupied, is_explosion,
               anchor_x, anchor_y, box_width, box_height, keep_found,
        output ready
    );
endinterface

interface aos_result_if import aos_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [SLOT_BITS-1:0]  hit_slot;
    logic                  hit_valid;
    logic [TOTAL_BITS-1:0] found_total;
    logic                  list_full;
    logic                  last_of_run;

    modport source (
        output valid, hit_slot, hit_valid, found_total, list_full, last_of_run,
        input  ready
    );

    modport sink (
        input  valid, hit_slot, hit_valid, found_total, list_full, last_of_run,
        output ready
    );
endinterface

// ===== hdl/aos_apb_regs.sv =====
// APB-style configuration register file holding the list capacity.
// Depends on aos_pkg.
`timescale 1ns / 1ps

module aos_apb_regs import aos_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    output logic [CAP_BITS-1:0]   capacity
);

    logic [CAP_BITS-1:0] cap_reg;
    logic [CAP_BITS-1:0] cap_next;
    logic                hit_cap;

    assign hit_cap = (paddr[PADDR_BITS-1:2] == REG_LIST_CAPACITY);

    always_comb
    begin
        cap_next = cap_reg;
        if (psel && penable && pwrite && hit_cap)
        begin
            cap_next = pwdata[CAP_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    assign prdata   = hit_cap ? PDATA_BITS'(cap_reg) : '0;
    assign pready   = 1'b1;
    assign capacity = cap_reg;

endmodule

// ===== hdl/aos_ctrl.sv =====
// Controller state machine that sequences slot writes, query scans and summaries.
// Depends on aos_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps

module aos_ctrl import aos_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       item_kind,
    input  dp_status_t status,
    output logic       item_ready,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (item_kind == KIND_QUERY)
                    begin
                        cmd.load_query = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        cmd.write_slot = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.full)
                begin
                    state_next = ST_SUMMARY;
                end
                else if (status.hit)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit_hit = 1'b1;
                        cmd.advance  = 1'b1;
                        if (status.last)
                        begin
                            state_next = ST_SUMMARY;
                        end
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                    if (status.last)
                    begin
                        state_next = ST_SUMMARY;
                    end
                end
            end
            ST_SUMMARY:
            begin
                if (status.out_free)
                begin
                    cmd.emit_summary = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/aos_dp.sv =====
// Datapath: slot marks, box memory, scan pointer, overlap test and result register.
// Depends on aos_pkg and aos_result_if; controlled by aos_ctrl.
`timescale 1ns / 1ps

module aos_dp import aos_pkg::*; (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dp_cmd_t                      cmd,
    output dp_status_t                   status,
    input  logic [CAP_BITS-1:0]          capacity,
    input  logic [SLOT_BITS-1:0]         slot_index,
    input  logic                         slot_occupied,
    input  logic                         is_explosion,
    input  logic signed [COORD_BITS-1:0] anchor_x,
    input  logic signed [COORD_BITS-1:0] anchor_y,
    input  logic [SIZE_BITS-1:0]         box_width,
    input  logic [SIZE_BITS-1:0]         box_height,
    input  logic                         keep_found,
    aos_result_if.source                 result
);

    box_t box_mem [TABLE_DEPTH];
    box_t box_rd_reg;

    logic [TABLE_DEPTH-1:0] occ_reg;
    logic [TABLE_DEPTH-1:0] occ_next;
    logic [TABLE_DEPTH-1:0] expl_reg;
    logic [TABLE_DEPTH-1:0] expl_next;
    logic [TABLE_DEPTH-1:0] found_reg;
    logic [TABLE_DEPTH-1:0] found_next;
    logic [CNT_BITS-1:0]    count_reg;
    logic [CNT_BITS-1:0]    count_next;
    logic [CNT_BITS-1:0]    count_inc;
    logic [IDX_BITS-1:0]    ptr_reg;
    logic [IDX_BITS-1:0]    ptr_next;

    logic [SEL_BITS-1:0]    self_slot_reg;
    logic                   self_skip_reg;
    logic signed [EXT_BITS-1:0] qx1_reg;
    logic signed [EXT_BITS-1:0] qx2_reg;
    logic signed [EXT_BITS-1:0] qy1_reg;
    logic signed [EXT_BITS-1:0] qy2_reg;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SLOT_BITS-1:0]   out_slot_reg;
    logic                   out_hit_reg;
    logic [TOTAL_BITS-1:0]  out_total_reg;
    logic                   out_full_reg;
    logic                   out_last_reg;

    logic [SEL_BITS-1:0]    wr_sel;
    logic                   wr_ok;
    logic [IDX_BITS-1:0]    wr_idx;

    logic signed [EXT_BITS-1:0] in_x;
    logic signed [EXT_BITS-1:0] in_y;
    logic signed [EXT_BITS-1:0] in_hw;
    logic signed [EXT_BITS-1:0] in_h;
    logic signed [EXT_BITS-1:0] ob_x;
    logic signed [EXT_BITS-1:0] ob_y;
    logic signed [EXT_BITS-1:0] ob_hw;
    logic signed [EXT_BITS-1:0] ob_h;
    logic signed [EXT_BITS-1:0] ox1;
    logic signed [EXT_BITS-1:0] ox2;
    logic signed [EXT_BITS-1:0] oy1;
    logic signed [EXT_BITS-1:0] oy2;

    logic                   overlap;
    logic                   candidate;
    logic [LVL_BITS-1:0]    cap_raw;
    logic [LVL_BITS-1:0]    cap_lvl;
    logic                   full_now;
    logic                   full_after;
    logic                   out_free;

    assign wr_sel = SEL_BITS'(slot_index);
    assign wr_ok  = (wr_sel < SEL_BITS'(TABLE_DEPTH));
    assign wr_idx = wr_sel[IDX_BITS-1:0];

    assign in_x  = EXT_BITS'(anchor_x);
    assign in_y  = EXT_BITS'(anchor_y);
    assign in_hw = $signed(EXT_BITS'(box_width >> 1));
    assign in_h  = $signed(EXT_BITS'(box_height));

    assign ob_x  = EXT_BITS'($signed(box_rd_reg.x));
    assign ob_y  = EXT_BITS'($signed(box_rd_reg.y));
    assign ob_hw = $signed(EXT_BITS'(box_rd_reg.w >> 1));
    assign ob_h  = $signed(EXT_BITS'(box_rd_reg.h));

    assign ox1 = ob_x - ob_hw;
    assign ox2 = ob_x + ob_hw;
    assign oy1 = ob_y - ob_h;
    assign oy2 = ob_y;

    assign overlap = !(qx1_reg > ox2) && !(qx2_reg < ox1)
                  && !(qy1_reg > oy2) && !(oy1 > qy2_reg);

    assign candidate = occ_reg[ptr_reg] && !expl_reg[ptr_reg] && !found_reg[ptr_reg]
                    && !(self_skip_reg && (SEL_BITS'(ptr_reg) == self_slot_reg));

    // The capacity register is clamped into the supported list range.
    assign cap_raw = LVL_BITS'(capacity);
    always_comb
    begin
        if (cap_raw == '0)
        begin
            cap_lvl = LVL_BITS'(1);
        end
        else if (cap_raw > LVL_BITS'(LIST_DEPTH))
        begin
            cap_lvl = LVL_BITS'(LIST_DEPTH);
        end
        else
        begin
            cap_lvl = cap_raw;
        end
    end

    assign count_inc  = count_reg + CNT_BITS'(1);
    assign full_now   = (LVL_BITS'(count_reg) >= cap_lvl);
    assign full_after = (LVL_BITS'(count_inc) >= cap_lvl);
    assign out_free   = !out_valid_reg || result.ready;

    assign status.full     = full_now;
    assign status.hit      = candidate && overlap;
    assign status.last     = (SEL_BITS'(ptr_reg) == SEL_BITS'(TABLE_DEPTH - 1));
    assign status.out_free = out_free;

    always_comb
    begin
        if (cmd.load_query)
        begin
            ptr_next = '0;
        end
        else if (cmd.advance)
        begin
            ptr_next = ptr_reg + IDX_BITS'(1);
        end
        else
        begin
            ptr_next = ptr_reg;
        end
    end

    always_comb
    begin
        occ_next   = occ_reg;
        expl_next  = expl_reg;
        found_next = found_reg;
        count_next = count_reg;
        if (cmd.write_slot && wr_ok)
        begin
            occ_next[wr_idx]  = slot_occupied;
            expl_next[wr_idx] = is_explosion;
        end
        if (cmd.load_query && !keep_found)
        begin
            found_next = '0;
            count_next = '0;
        end
        if (cmd.emit_hit)
        begin
            found_next[ptr_reg] = 1'b1;
            count_next          = count_inc;
        end
    end

    always_comb
    begin
        if (cmd.emit_hit || cmd.emit_summary)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            expl_reg      <= '0;
            found_reg     <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            expl_reg      <= expl_next;
            found_reg     <= found_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The read port follows the next pointer, so in a scan the registered box always matches ptr_reg.
    always_ff @(posedge clk)
    begin
        if (cmd.write_slot && wr_ok)
        begin
            box_mem[wr_idx] <= '{x: anchor_x, y: anchor_y, w: box_width, h: box_height};
        end
        box_rd_reg <= box_mem[ptr_next];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            self_slot_reg <= wr_sel;
            self_skip_reg <= slot_occupied;
            qx1_reg       <= in_x - in_hw;
            qx2_reg       <= in_x + in_hw;
            qy1_reg       <= in_y - in_h;
            qy2_reg       <= in_y;
        end
        if (cmd.emit_hit)
        begin
            out_slot_reg  <= SLOT_BITS'(ptr_reg);
            out_hit_reg   <= 1'b1;
            out_total_reg <= TOTAL_BITS'(count_inc);
            out_full_reg  <= full_after;
            out_last_reg  <= 1'b0;
        end
        else if (cmd.emit_summary)
        begin
            out_slot_reg  <= '0;
            out_hit_reg   <= 1'b0;
            out_total_reg <= TOTAL_BITS'(count_reg);
            out_full_reg  <= full_now;
            out_last_reg  <= 1'b1;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.hit_slot    = out_slot_reg;
    assign result.hit_valid   = out_hit_reg;
    assign result.found_total = out_total_reg;
    assign result.list_full   = out_full_reg;
    assign result.last_of_run = out_last_reg;

endmodule

// ===== hdl/aabb_overlap_scan.sv =====
// Top level of the box overlap scan: configuration registers, controller and datapath.
// Depends on aos_pkg, aos_if, aos_apb_regs, aos_ctrl and aos_dp.
//
// Channel   Direction  Handshake             Transaction
// item      in         item.valid/ready      write one slot, or run one overlap query
// result    out        result.valid/ready    one hit per overlapping slot, then a summary
// APB       in/out     psel/penable/pready   list capacity register at byte address 0
//
// A write transaction is taken in the idle state. A query is loaded, then scans every table
// slot in turn (TABLE_DEPTH = 64), then emits the summary; the scan ends early when the found
// list fills. The scan walks the box memory one read a cycle while no hit is waiting.
// A hit waits in place while the result register is held by a stalled sink.
// Reset clears all slot marks and the found count at once; no clearing pass is needed.
`timescale 1ns / 1ps

module aabb_overlap_scan import aos_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    aos_item_if.sink              item,
    aos_result_if.source          result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready
);

    logic [CAP_BITS-1:0] capacity;
    logic                item_ready;
    dp_cmd_t             cmd;
    dp_status_t          status;

    aos_apb_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    aos_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_kind  (item.kind),
        .status     (status),
        .item_ready (item_ready),
        .cmd        (cmd)
    );

    aos_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .capacity      (capacity),
        .slot_index    (item.slot_index),
        .slot_occupied (item.slot_occupied),
        .is_explosion  (item.is_explosion),
        .anchor_x      (item.anchor_x),
        .anchor_y      (item.anchor_y),
        .box_width     (item.box_width),
        .box_height    (item.box_height),
        .keep_found    (item.keep_found),
        .result        (result)
    );

    assign item.ready = item_ready;

endmodule

// ===== hdl/aos_checker.sv =====
// Port-level checker for the overlap scan, attached to the top level by a bind.
// Depends on aos_pkg and aabb_overlap_scan.
`timescale 1ns / 1ps

module aos_checker import aos_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  item_valid,
    input logic                  item_ready,
    input logic                  item_kind,
    input logic                  result_valid,
    input logic                  result_ready,
    input logic [SLOT_BITS-1:0]  hit_slot,
    input logic                  hit_valid,
    input logic [TOTAL_BITS-1:0] found_total,
    input logic                  list_full,
    input logic                  last_of_run
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(hit_slot)
            && $stable(hit_valid) && $stable(found_total) && $stable(list_full)
            && $stable(last_of_run))
        else $error("Stalled result transaction changed.");

    a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (hit_valid != last_of_run))
        else $error("Result is neither a hit nor a summary, or both.");

    a_summary_slot: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_of_run |-> (hit_slot == '0))
        else $error("Summary transaction carries a nonzero slot.");

    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && hit_valid |-> (found_total != '0))
        else $error("Hit transaction reports an empty found list.");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_kind == KIND_QUERY) |=> !item_ready)
        else $error("Item accepted during a running query scan.");

endmodule

bind aabb_overlap_scan aos_checker u_aos_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_kind    (item.kind),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .hit_slot     (result.hit_slot),
    .hit_valid    (result.hit_valid),
    .found_total  (result.found_total),
    .list_full    (result.list_full),
    .last_of_run  (result.last_of_run)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for aabb_overlap_scan: drives write and query transactions,
// predicts every hit and summary result, and checks them in order.
// Depends on aos_pkg, aos_if and the aabb_overlap_scan RTL.
`timescale 1ns / 1ps

module testbench;
    import aos_pkg::*;

    typedef struct {
        logic                         kind;
        logic [SLOT_BITS-1:0]         slot;
        logic                         occ;
        logic                         expl;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [SIZE_BITS-1:0]         w;
        logic [SIZE_BITS-1:0]         h;
        logic                         keep;
    } scan_item_t;

    typedef struct {
        logic [SLOT_BITS-1:0]  slot;
        logic                  hit;
        logic [TOTAL_BITS-1:0] total;
        logic                  full;
        logic                  last;
    } scan_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [PDATA_BITS-1:0] pwdata;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    aos_item_if   item_bus ();
    aos_result_if result_bus ();

    aabb_overlap_scan uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_bus),
        .result  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic                         occ_marks   [TABLE_DEPTH];
    logic                         expl_marks  [TABLE_DEPTH];
    logic                         found_marks [TABLE_DEPTH];
    logic signed [COORD_BITS-1:0] box_x       [TABLE_DEPTH];
    logic signed [COORD_BITS-1:0] box_y       [TABLE_DEPTH];
    logic [SIZE_BITS-1:0]         box_w       [TABLE_DEPTH];
    logic [SIZE_BITS-1:0]         box_h       [TABLE_DEPTH];
    int                           found_count;
    logic [CAP_BITS-1:0]          list_capacity;

    scan_result_t pending_results[$];
    int           errors;
    bit           idle_tx;
    bit           idle_rx;
    int           hold_left;

    always #10 clk = ~clk;

    initial
    begin
        #(20_000_000);
        $display("testbench: done, errors");
        $finish;
    end

    function automatic scan_item_t make_item(input logic kind, input int slot, input logic occ,
                                             input logic expl, input int x, input int y,
                                             input int w, input int h, input logic keep);
        scan_item_t it;
        it.kind = kind;
        it.slot = SLOT_BITS'(slot);
        it.occ  = occ;
        it.expl = expl;
        it.x    = COORD_BITS'(x);
        it.y    = COORD_BITS'(y);
        it.w    = SIZE_BITS'(w);
        it.h    = SIZE_BITS'(h);
        it.keep = keep;
        return it;
    endfunction

    function automatic void predict_scan(input scan_item_t it);
        int     cap;
        longint qx1, qx2, qy1, qy2, ox1, ox2, oy1, oy2;
        bit     full;
        if (it.kind == KIND_WRITE)
        begin
            occ_marks[it.slot]  = it.occ;
            expl_marks[it.slot] = it.expl;
            box_x[it.slot]      = it.x;
            box_y[it.slot]      = it.y;
            box_w[it.slot]      = it.w;
            box_h[it.slot]      = it.h;
            return;
        end
        cap = list_capacity;
        if (cap < 1)
            cap = 1;
        if (cap > LIST_DEPTH)
            cap = LIST_DEPTH;
        if (!it.keep)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                found_marks[i] = 1'b0;
            found_count = 0;
        end
        qx1 = longint'(it.x) - longint'(it.w >> 1);
        qx2 = longint'(it.x) + longint'(it.w >> 1);
        qy1 = longint'(it.y) - longint'(it.h);
        qy2 = longint'(it.y);
        full = (found_count >= cap);
        for (int i = 0; i < TABLE_DEPTH && !full; i++)
        begin
            if (!occ_marks[i] || expl_marks[i] || found_marks[i])
                continue;
            if (it.occ && i == it.slot)
                continue;
            ox1 = longint'(box_x[i]) - longint'(box_w[i] >> 1);
            ox2 = longint'(box_x[i]) + longint'(box_w[i] >> 1);
            oy1 = longint'(box_y[i]) - longint'(box_h[i]);
            oy2 = longint'(box_y[i]);
            if (qx1 > ox2 || qx2 < ox1 || qy1 > oy2 || oy1 > qy2)
                continue;
            found_marks[i] = 1'b1;
            found_count++;
            full = (found_count >= cap);
            pending_results.push_back('{SLOT_BITS'(i), 1'b1, TOTAL_BITS'(found_count),
                                        full, 1'b0});
        end
        pending_results.push_back('{'0, 1'b0, TOTAL_BITS'(found_count), full, 1'b1});
    endfunction

    task automatic send_item(input scan_item_t it);
        @(negedge clk);
        while (idle_tx && $urandom_range(99) < 19)
        begin
            item_bus.valid = 1'b0;
            @(negedge clk);
        end
        item_bus.kind          = it.kind;
        item_bus.slot_index    = it.slot;
        item_bus.slot_occupied = it.occ;
        item_bus.is_explosion  = it.expl;
        item_bus.anchor_x      = it.x;
        item_bus.anchor_y      = it.y;
        item_bus.box_width     = it.w;
        item_bus.box_height    = it.h;
        item_bus.keep_found    = it.keep;
        item_bus.valid         = 1'b1;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        predict_scan(it);
    endtask

    task automatic drain_results();
        @(negedge clk);
        item_bus.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic set_capacity(input int value);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {REG_LIST_CAPACITY, 2'b00};
        pwdata  = PDATA_BITS'(value);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        list_capacity = CAP_BITS'(value);
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[CAP_BITS-1:0] !== list_capacity)
        begin
            $display("%0t: list_capacity read expected %0d got %0d", $time, list_capacity,
                     prdata[CAP_BITS-1:0]);
            errors++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic int near_coord(input int center);
        int v;
        v = center + int'($urandom_range(128)) - 64;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v;
    endfunction

    function automatic int pick_size();
        if ($urandom_range(99) < 80)
            return $urandom_range(127);
        return $urandom_range(1023);
    endfunction

    task automatic write_dense_boxes();
        for (int s = 8; s < 32; s++)
            send_item(make_item(KIND_WRITE, s, 1'b1, 1'b0, int'($urandom_range(32)) - 16,
                                int'($urandom_range(32)) - 16, $urandom_range(40, 80),
                                $urandom_range(40, 80), 1'($urandom)));
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        scan_result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result expected none got slot %0d", $time,
                         result_bus.hit_slot);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("hit_slot", 8'(want.slot), 8'(result_bus.hit_slot));
                check_field("hit_valid", 8'(want.hit), 8'(result_bus.hit_valid));
                check_field("found_total", 8'(want.total), 8'(result_bus.found_total));
                check_field("list_full", 8'(want.full), 8'(result_bus.list_full));
                check_field("last_of_run", 8'(want.last), 8'(result_bus.last_of_run));
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_bus.ready = 1'b0;
            hold_left--;
        end
        else if (idle_rx)
            result_bus.ready = ($urandom_range(99) >= 19);
        else
            result_bus.ready = 1'b1;
    end

    task automatic test_directed();
        send_item(make_item(KIND_QUERY, 0, 1'b0, 1'b1, 0, 0, 10, 10, 1'b0));
        send_item(make_item(KIND_WRITE, 0, 1'b1, 1'b0, 0, 0, 10, 10, 1'b1));
        send_item(make_item(KIND_WRITE, 63, 1'b1, 1'b0, -32768, -32768, 1023, 1023, 1'b0));
        send_item(make_item(KIND_WRITE, 1, 1'b1, 1'b1, 0, 0, 10, 10, 1'b0));
        send_item(make_item(KIND_WRITE, 2, 1'b0, 1'b0, 0, 0, 10, 10, 1'b1));
        send_item(make_item(KIND_WRITE, 3, 1'b1, 1'b0, 32767, 32767, 0, 0, 1'b0));
        send_item(make_item(KIND_WRITE, 4, 1'b1, 1'b0, 10, 0, 10, 0, 1'b0));
        send_item(make_item(KIND_QUERY, 0, 1'b1, 1'b0, 0, 0, 10, 10, 1'b0));
        send_item(make_item(KIND_QUERY, 0, 1'b0, 1'b1, 0, 0, 10, 10, 1'b1));
        send_item(make_item(KIND_QUERY, 0, 1'b0, 1'b0, 0, 0, 10, 10, 1'b1));
        send_item(make_item(KIND_QUERY, 63, 1'b1, 1'b1, 32767, 32767, 0, 0, 1'b0));
        send_item(make_item(KIND_QUERY, 5, 1'b0, 1'b0, -32768, -32768, 1023, 1023, 1'b0));
        send_item(make_item(KIND_QUERY, 4, 1'b0, 1'b0, 16, 0, 0, 0, 1'b0));
        send_item(make_item(KIND_QUERY, 1, 1'b1, 1'b0, 32000, 32000, 1023, 1023, 1'b0));
        drain_results();
        set_capacity(1);
        send_item(make_item(KIND_QUERY, 0, 1'b0, 1'b0, 0, 0, 1023, 1023, 1'b0));
        send_item(make_item(KIND_QUERY, 0, 1'b0, 1'b0, 0, 0, 1023, 1023, 1'b1));
        drain_results();
        set_capacity(0);
        send_item(make_item(KIND_QUERY, 0, 1'b1, 1'b0, 0, 0, 1023, 1023, 1'b0));
        drain_results();
        set_capacity(31);
        send_item(make_item(KIND_QUERY, 0, 1'b1, 1'b0, 0, 0, 1023, 1023, 1'b0));
        drain_results();
    endtask

    task automatic test_capacity();
        int caps[7];
        caps = '{1, 16, 31, 0, 17, 8, 5};
        caps[6] = $urandom_range(31);
        write_dense_boxes();
        drain_results();
        foreach (caps[c])
        begin
            set_capacity(caps[c]);
            for (int q = 0; q < 4; q++)
                send_item(make_item(KIND_QUERY, $urandom_range(8, 31), 1'($urandom),
                                    1'($urandom), 0, 0, 64, 64, q != 0));
            drain_results();
        end
    endtask

    task automatic test_backpressure();
        set_capacity(16);
        idle_tx = 1'b0;
        idle_rx = 1'b0;
        hold_left = 400;
        for (int q = 0; q < 20; q++)
            send_item(make_item(KIND_QUERY, 63, 1'b0, 1'($urandom), 0, 0, 64, 64, 1'b0));
        for (int n = 0; n < 30; n++)
            send_item(make_item($urandom_range(99) < 40, $urandom, 1'($urandom),
                                1'($urandom), near_coord(0), near_coord(0), pick_size(),
                                pick_size(), 1'($urandom)));
        drain_results();
        idle_tx = 1'b1;
        idle_rx = 1'b1;
    endtask

    task automatic test_random();
        int cx;
        int cy;
        int sel;
        for (int phase = 0; phase < 5; phase++)
        begin
            set_capacity($urandom_range(31));
            sel = $urandom_range(3);
            cx = (sel == 0) ? 0 : (sel == 1) ? 32700 : (sel == 2) ? -32700
                 : int'($urandom_range(60000)) - 30000;
            cy = (sel == 0) ? 0 : (sel == 1) ? -32700 : (sel == 2) ? 32700
                 : int'($urandom_range(60000)) - 30000;
            for (int n = 0; n < 50; n++)
            begin
                if ($urandom_range(99) < 80)
                    send_item(make_item($urandom_range(99) < 35, $urandom,
                                        $urandom_range(99) < 85, $urandom_range(99) < 10,
                                        near_coord(cx), near_coord(cy), pick_size(),
                                        pick_size(), $urandom_range(99) < 60));
                else
                    send_item(make_item(1'($urandom), $urandom, 1'($urandom), 1'($urandom),
                                        $urandom, $urandom, $urandom, $urandom,
                                        1'($urandom)));
            end
            drain_results();
        end
    endtask

    initial
    begin
        clk                     = 1'b0;
        rst_n                   = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        item_bus.valid          = 1'b0;
        item_bus.kind           = KIND_WRITE;
        item_bus.slot_index     = '0;
        item_bus.slot_occupied  = 1'b0;
        item_bus.is_explosion   = 1'b0;
        item_bus.anchor_x       = '0;
        item_bus.anchor_y       = '0;
        item_bus.box_width      = '0;
        item_bus.box_height     = '0;
        item_bus.keep_found     = 1'b0;
        result_bus.ready        = 1'b0;
        errors                  = 0;
        idle_tx                 = 1'b1;
        idle_rx                 = 1'b1;
        hold_left               = 0;
        found_count             = 0;
        list_capacity           = CAP_RESET;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            occ_marks[i]   = 1'b0;
            expl_marks[i]  = 1'b0;
            found_marks[i] = 1'b0;
            box_x[i]       = '0;
            box_y[i]       = '0;
            box_w[i]       = '0;
            box_h[i]       = '0;
        end
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_capacity();
        test_backpressure();
        test_random();

        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/aos_pkg.sv
hdl/aos_if.sv
hdl/aos_apb_regs.sv
hdl/aos_ctrl.sv
hdl/aos_dp.sv
hdl/aabb_overlap_scan.sv
hdl/aos_checker.sv
tb/sv/testbench.sv
